[design/cla_pkg.sv]
// ---------------------------------------------------------------------------
// cla_pkg
// Shared types and constants of the command line argument splitter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cla_pkg;

	// default width of the backslash run counter
	localparam int RUN_COUNT_BITS_DEF = 16;

	// code unit width and saturation limit of the reported counts
	localparam int CU_BITS = 16;

	// characters with a meaning to the parser
	localparam logic [CU_BITS-1:0] CH_QUOTE  = 16'h0022;
	localparam logic [CU_BITS-1:0] CH_BSLASH = 16'h005C;
	localparam logic [CU_BITS-1:0] CH_SPACE  = 16'h0020;
	localparam logic [CU_BITS-1:0] CH_TAB    = 16'h0009;

	// parse mode codes (the fourth code is handled as between arguments)
	localparam logic [1:0] MODE_PROG    = 2'd0;
	localparam logic [1:0] MODE_BETWEEN = 2'd1;
	localparam logic [1:0] MODE_IN_ARG  = 2'd2;

	// parser state apart from the backslash run counter
	typedef struct packed {
		logic [1:0]         mode;
		logic               quoted;
		logic               quote_pending;
		logic [CU_BITS-1:0] pending_slashes;
	} state_t;

	// one result item
	typedef struct packed {
		logic [CU_BITS-1:0] backslash_count;
		logic               has_char;
		logic [CU_BITS-1:0] char_out;
		logic               arg_end;
		logic               is_program_name;
		logic               last;
	} result_t;

endpackage

`default_nettype wire

[design/cla_step.sv]
// ---------------------------------------------------------------------------
// cla_step
// Next-state and result logic for one code unit or end-of-line item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cla_step #(
	parameter int RUN_COUNT_BITS = cla_pkg::RUN_COUNT_BITS_DEF
) (
	input  wire logic [cla_pkg::CU_BITS-1:0] code_unit,
	input  wire logic                        line_end,
	input  wire cla_pkg::state_t             state,
	input  wire logic [RUN_COUNT_BITS-1:0]   slash_run,
	output cla_pkg::state_t                  state_nxt,
	output logic [RUN_COUNT_BITS-1:0]        slash_run_nxt,
	output logic                             emit,
	output cla_pkg::result_t                 result
);

	localparam int CW = cla_pkg::CU_BITS;
	localparam int SW = ((RUN_COUNT_BITS > CW) ? RUN_COUNT_BITS : CW) + 1;

	// saturate a wide count to the code unit width
	function automatic logic [CW-1:0] sat_cnt(input logic [SW-1:0] v);
		logic [CW-1:0] r;
		r = (|v[SW-1:CW]) ? {CW{1'b1}} : v[CW-1:0];
		return r;
	endfunction

	logic                      is_quote;
	logic                      is_bslash;
	logic                      is_blank;
	logic [CW-1:0]             carry;
	logic                      q_eff;
	logic [RUN_COUNT_BITS-1:0] run_eff;
	logic [SW-1:0]             run_sum;
	logic [CW-1:0]             half_sat;
	logic                      to_arg;

	assign is_quote  = (code_unit == cla_pkg::CH_QUOTE);
	assign is_bslash = (code_unit == cla_pkg::CH_BSLASH);
	assign is_blank  = (code_unit == cla_pkg::CH_SPACE) || (code_unit == cla_pkg::CH_TAB);

	// argument-body inputs: pending quote resolves into a carry, a new argument starts clean
	always_comb begin
		to_arg  = (state.mode == cla_pkg::MODE_IN_ARG);
		carry   = (to_arg && state.quote_pending) ? state.pending_slashes : '0;
		q_eff   = to_arg && state.quoted && !state.quote_pending;
		run_eff = to_arg ? slash_run : '0;
		run_sum = SW'(carry) + SW'(run_eff);
		half_sat = sat_cnt(SW'(run_eff >> 1));
	end

	// main step
	always_comb begin
		state_nxt     = state;
		slash_run_nxt = slash_run;
		emit          = 1'b0;
		result        = '0;

		if (state.mode == cla_pkg::MODE_PROG) begin
			// program name: quotes toggle, an unquoted blank ends it, everything else is literal
			result.is_program_name = 1'b1;
			if (line_end) begin
				state_nxt     = '0;
				slash_run_nxt = '0;
				emit          = 1'b1;
				result.arg_end = 1'b1;
				result.last    = 1'b1;
			end else if (is_quote) begin
				state_nxt.quoted = !state.quoted;
			end else if (!state.quoted && is_blank) begin
				state_nxt.mode   = cla_pkg::MODE_BETWEEN;
				state_nxt.quoted = 1'b0;
				emit             = 1'b1;
				result.arg_end   = 1'b1;
			end else begin
				emit            = 1'b1;
				result.has_char = 1'b1;
				result.char_out = code_unit;
			end
		end else if (!to_arg && line_end) begin
			// line end between arguments
			state_nxt     = '0;
			slash_run_nxt = '0;
			emit          = 1'b1;
			result.last   = 1'b1;
		end else if (!to_arg && is_blank) begin
			// skip separators
		end else if (to_arg && state.quote_pending && !line_end && is_quote) begin
			// doubled quote inside quotes: literal quote
			state_nxt.quote_pending   = 1'b0;
			state_nxt.pending_slashes = '0;
			emit                      = 1'b1;
			result.backslash_count    = state.pending_slashes;
			result.has_char           = 1'b1;
			result.char_out           = cla_pkg::CH_QUOTE;
		end else begin
			// argument body
			state_nxt.mode            = cla_pkg::MODE_IN_ARG;
			state_nxt.quoted          = q_eff;
			state_nxt.quote_pending   = 1'b0;
			state_nxt.pending_slashes = '0;
			slash_run_nxt             = run_eff;
			if (line_end) begin
				state_nxt     = '0;
				slash_run_nxt = '0;
				emit          = 1'b1;
				result.backslash_count = sat_cnt(run_sum);
				result.arg_end         = 1'b1;
				result.last            = 1'b1;
			end else if (is_bslash) begin
				if (!(&run_eff)) begin
					slash_run_nxt = run_eff + 1'b1;
				end
				if (carry != '0) begin
					emit                   = 1'b1;
					result.backslash_count = carry;
				end
			end else if (is_quote) begin
				slash_run_nxt = '0;
				if (run_eff[0]) begin
					emit                   = 1'b1;
					result.backslash_count = half_sat;
					result.has_char        = 1'b1;
					result.char_out        = cla_pkg::CH_QUOTE;
				end else if (q_eff) begin
					state_nxt.quote_pending   = 1'b1;
					state_nxt.pending_slashes = half_sat;
				end else begin
					state_nxt.quoted = 1'b1;
					if (half_sat != '0) begin
						emit                   = 1'b1;
						result.backslash_count = half_sat;
					end
				end
			end else begin
				slash_run_nxt          = '0;
				emit                   = 1'b1;
				result.backslash_count = sat_cnt(run_sum);
				if (!q_eff && is_blank) begin
					state_nxt.mode = cla_pkg::MODE_BETWEEN;
					result.arg_end = 1'b1;
				end else begin
					result.has_char = 1'b1;
					result.char_out = code_unit;
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/command_line_argument_splitter.sv]
// ---------------------------------------------------------------------------
// command_line_argument_splitter
// Splits a stream of UTF-16 code units into arguments by Windows rules.
// ---------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle unless a stalled result holds the input register; cla_step is combinational.
// Items that cause no result are consumed without an output slot.
// Reset (arst_n low, asynchronous): parser back in program name mode, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module command_line_argument_splitter #(
	parameter int RUN_COUNT_BITS = cla_pkg::RUN_COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [cla_pkg::CU_BITS-1:0] code_unit,
	input  wire logic                        line_end,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [cla_pkg::CU_BITS-1:0]      backslash_count,
	output logic                             has_char,
	output logic [cla_pkg::CU_BITS-1:0]      char_out,
	output logic                             arg_end,
	output logic                             is_program_name,
	output logic                             last
);

	logic                          valid_s1;
	logic [cla_pkg::CU_BITS-1:0]   code_unit_s1;
	logic                          line_end_s1;
	cla_pkg::state_t               state_q;
	cla_pkg::state_t               state_nxt;
	logic [RUN_COUNT_BITS-1:0]     slash_run_q;
	logic [RUN_COUNT_BITS-1:0]     slash_run_nxt;
	logic                          emit;
	cla_pkg::result_t              result;
	cla_pkg::result_t              result_q;
	logic                          result_valid_q;
	logic                          advance;
	logic                          accept;

	// handshake: the input register advances whenever the result register is free
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_unit_s1 <= code_unit;
			line_end_s1  <= line_end;
		end
	end

	// step logic
	cla_step #(
		.RUN_COUNT_BITS(RUN_COUNT_BITS)
	) u_step (
		.code_unit    (code_unit_s1),
		.line_end     (line_end_s1),
		.state        (state_q),
		.slash_run    (slash_run_q),
		.state_nxt    (state_nxt),
		.slash_run_nxt(slash_run_nxt),
		.emit         (emit),
		.result       (result)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			slash_run_q <= '0;
		end else if (advance) begin
			state_q     <= state_nxt;
			slash_run_q <= slash_run_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign result_valid    = result_valid_q;
	assign backslash_count = result_q.backslash_count;
	assign has_char        = result_q.has_char;
	assign char_out        = result_q.char_out;
	assign arg_end         = result_q.arg_end;
	assign is_program_name = result_q.is_program_name;
	assign last            = result_q.last;

endmodule

`default_nettype wire

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for command_line_argument_splitter. A directed table
// covers program name quoting, backslash and quote rules, the doubled quote
// and line ends in the program name and between arguments. Two long
// backslash runs end at a quote and at a line end. Random command lines
// follow. Every result is checked against an in-bench model of the parser,
// with random idle and stall bursts on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int                 RUN_BITS     = cla_pkg::RUN_COUNT_BITS_DEF;
	localparam longint             RUN_MAX      = (longint'(1) << RUN_BITS) - 1;
	localparam int                 RANDOM_ITEMS = 730;
	localparam int                 CALM_ITEMS   = 610;
	localparam int                 HOLD_AT      = 200;
	localparam int                 DRAIN_AT     = 450;
	localparam int                 HOLD_CYCLES  = 300;
	localparam int                 LONG_RUN     = 21;
	localparam longint             CYCLE_LIMIT  = 100000;
	localparam cla_pkg::result_t   NO_PIECE     = '0;

	logic                          clk;
	logic                          arst_n;
	logic                          item_valid;
	logic                          item_stall;
	logic [cla_pkg::CU_BITS-1:0]   code_unit;
	logic                          line_end;
	logic                          result_valid;
	logic                          result_stall;
	logic [cla_pkg::CU_BITS-1:0]   backslash_count;
	logic                          has_char;
	logic [cla_pkg::CU_BITS-1:0]   char_out;
	logic                          arg_end;
	logic                          is_program_name;
	logic                          last;

	command_line_argument_splitter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.code_unit       (code_unit),
		.line_end        (line_end),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.backslash_count (backslash_count),
		.has_char        (has_char),
		.char_out        (char_out),
		.arg_end         (arg_end),
		.is_program_name (is_program_name),
		.last            (last)
	);

	// one row of the directed table
	typedef struct {
		logic [cla_pkg::CU_BITS-1:0] cu;
		logic                        le;
		bit                          typed;
		cla_pkg::result_t            want;
	} stim_row_t;

	stim_row_t         directed_rows[$];
	cla_pkg::result_t  pieces_due[$];
	int                error_count;
	int                random_items;
	bit                calm;
	bit                hold_req;
	longint            cycle_count;

	// parser model state
	logic [1:0]        split_mode;
	bit                in_quotes;
	longint unsigned   slash_count;
	bit                quote_held;
	logic [15:0]       held_slashes;

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [15:0] sat16(input longint unsigned v);
		return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic bit is_blank(input logic [cla_pkg::CU_BITS-1:0] cu);
		return (cu == cla_pkg::CH_SPACE) || (cu == cla_pkg::CH_TAB);
	endfunction

	function automatic cla_pkg::result_t piece(input longint unsigned cnt, input bit has,
			input logic [cla_pkg::CU_BITS-1:0] ch, input bit e, input bit prog, input bit l);
		cla_pkg::result_t r;
		r.backslash_count = sat16(cnt);
		r.has_char        = has;
		r.char_out        = has ? ch : '0;
		r.arg_end         = e;
		r.is_program_name = prog;
		r.last            = l;
		return r;
	endfunction

	task automatic reset_splitter();
		split_mode   = cla_pkg::MODE_PROG;
		in_quotes    = 0;
		slash_count  = 0;
		quote_held   = 0;
		held_slashes = '0;
	endtask

	// one unit inside an argument, carry being backslashes already owed
	task automatic arg_unit(input logic [cla_pkg::CU_BITS-1:0] cu, input bit le,
			input longint unsigned carry, output bit got, output cla_pkg::result_t r);
		longint unsigned n;
		got = 0;
		r = NO_PIECE;
		if (le) begin
			n = carry + slash_count;
			reset_splitter();
			got = 1;
			r = piece(n, 0, '0, 1, 0, 1);
		end else if (cu == cla_pkg::CH_BSLASH) begin
			if (slash_count < RUN_MAX)
				slash_count++;
			if (carry != 0) begin
				got = 1;
				r = piece(carry, 0, '0, 0, 0, 0);
			end
		end else if (cu == cla_pkg::CH_QUOTE) begin
			n = slash_count;
			slash_count = 0;
			if (n[0]) begin
				got = 1;
				r = piece(n >> 1, 1, cla_pkg::CH_QUOTE, 0, 0, 0);
			end else if (in_quotes) begin
				quote_held = 1;
				held_slashes = sat16(n >> 1);
			end else begin
				in_quotes = 1;
				if ((n >> 1) != 0) begin
					got = 1;
					r = piece(n >> 1, 0, '0, 0, 0, 0);
				end
			end
		end else begin
			n = carry + slash_count;
			slash_count = 0;
			got = 1;
			if (!in_quotes && is_blank(cu)) begin
				split_mode = cla_pkg::MODE_BETWEEN;
				r = piece(n, 0, '0, 1, 0, 0);
			end else begin
				r = piece(n, 1, cu, 0, 0, 0);
			end
		end
	endtask

	// advance the parser model by one accepted item
	task automatic split_unit(input logic [cla_pkg::CU_BITS-1:0] cu, input bit le,
			output bit got, output cla_pkg::result_t r);
		longint unsigned carry;
		got = 0;
		r = NO_PIECE;
		case (split_mode)
			cla_pkg::MODE_PROG: begin
				if (le) begin
					reset_splitter();
					got = 1;
					r = piece(0, 0, '0, 1, 1, 1);
				end else if (cu == cla_pkg::CH_QUOTE) begin
					in_quotes = !in_quotes;
				end else if (!in_quotes && is_blank(cu)) begin
					split_mode = cla_pkg::MODE_BETWEEN;
					in_quotes = 0;
					got = 1;
					r = piece(0, 0, '0, 1, 1, 0);
				end else begin
					got = 1;
					r = piece(0, 1, cu, 0, 1, 0);
				end
			end
			cla_pkg::MODE_IN_ARG: begin
				if (!quote_held) begin
					arg_unit(cu, le, 0, got, r);
				end else begin
					carry = held_slashes;
					quote_held = 0;
					held_slashes = '0;
					if (!le && cu == cla_pkg::CH_QUOTE) begin
						// doubled quote inside quotes, quoting goes on
						got = 1;
						r = piece(carry, 1, cla_pkg::CH_QUOTE, 0, 0, 0);
					end else begin
						in_quotes = 0;
						arg_unit(cu, le, carry, got, r);
					end
				end
			end
			default: begin
				// between arguments, also the unused fourth code
				if (le) begin
					reset_splitter();
					got = 1;
					r = piece(0, 0, '0, 0, 0, 1);
				end else if (!is_blank(cu)) begin
					split_mode = cla_pkg::MODE_IN_ARG;
					in_quotes = 0;
					slash_count = 0;
					quote_held = 0;
					held_slashes = '0;
					arg_unit(cu, 0, 0, got, r);
				end
			end
		endcase
	endtask

	task automatic flag_error(input string msg);
		$display("mismatch: %s", msg);
		error_count++;
	endtask

	task automatic add_row(input logic [cla_pkg::CU_BITS-1:0] cu, input logic le,
			input bit typed, input cla_pkg::result_t want);
		stim_row_t row;
		row.cu = cu;
		row.le = le;
		row.typed = typed;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// offer one item, wait for it to be taken, then record what it should cause
	task automatic offer_item(input logic [cla_pkg::CU_BITS-1:0] cu, input logic le,
			input bit typed, input cla_pkg::result_t want);
		bit               got;
		cla_pkg::result_t r;
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_valid <= 1'b1;
		code_unit  <= cu;
		line_end   <= le;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		split_unit(cu, le, got, r);
		if (typed)
			pieces_due.insert(pieces_due.size(), want);
		else if (got)
			pieces_due.insert(pieces_due.size(), r);
	endtask

	// one random command line, mostly well formed, sometimes pure noise
	task automatic send_line();
		int                          len;
		bit                          noisy;
		logic [cla_pkg::CU_BITS-1:0] cu;
		noisy = ($urandom_range(0, 9) == 0);
		len = $urandom_range(0, 12);
		repeat (len) begin
			if (noisy) begin
				cu = 16'($urandom_range(0, 65535));
			end else begin
				case ($urandom_range(0, 15))
					0, 1, 2: cu = cla_pkg::CH_QUOTE;
					3, 4, 5: cu = cla_pkg::CH_BSLASH;
					6, 7:    cu = cla_pkg::CH_SPACE;
					8:       cu = cla_pkg::CH_TAB;
					9, 10, 11, 12: cu = 16'h0061 + 16'($urandom_range(0, 25));
					default: cu = 16'($urandom_range(0, 65535));
				endcase
			end
			offer_item(cu, 1'b0, 0, NO_PIECE);
		end
		offer_item(16'($urandom_range(0, 65535)), 1'b1, 0, NO_PIECE);
		random_items += len + 1;
	endtask

	// compare one taken result with the oldest expectation
	task automatic check_piece();
		cla_pkg::result_t want;
		if (pieces_due.size() == 0) begin
			flag_error($sformatf("unexpected result count=%0d has=%0d char=%h end=%0d",
				backslash_count, has_char, char_out, arg_end));
			return;
		end
		want = pieces_due.pop_front();
		if (backslash_count !== want.backslash_count)
			flag_error($sformatf("backslash_count %0d, want %0d", backslash_count,
				want.backslash_count));
		if (has_char !== want.has_char)
			flag_error($sformatf("has_char %0d, want %0d", has_char, want.has_char));
		if (char_out !== want.char_out)
			flag_error($sformatf("char_out %h, want %h", char_out, want.char_out));
		if (arg_end !== want.arg_end)
			flag_error($sformatf("arg_end %0d, want %0d", arg_end, want.arg_end));
		if (is_program_name !== want.is_program_name)
			flag_error($sformatf("is_program_name %0d, want %0d", is_program_name,
				want.is_program_name));
		if (last !== want.last)
			flag_error($sformatf("last %0d, want %0d", last, want.last));
	endtask

	// result side: check taken items, drive stall bursts and the long hold
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				check_piece();
			if (hold_req) begin
				hold_req = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 2);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("command_line_argument_splitter test failed");
		$finish;
	end

	// stimulus
	initial begin
		bit hold_done;
		bit drain_done;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		code_unit    = '0;
		line_end     = 1'b0;
		error_count  = 0;
		random_items = 0;
		calm         = 0;
		hold_req     = 0;
		hold_done    = 0;
		drain_done   = 0;
		reset_splitter();

		// line end right after reset closes an empty program name
		add_row(16'h0000, 1'b1, 1, piece(0, 0, '0, 1, 1, 1));
		// extremes and code unit zero copied into the program name
		add_row(16'hFFFF, 1'b0, 1, piece(0, 1, 16'hFFFF, 0, 1, 0));
		add_row(16'h0000, 1'b0, 1, piece(0, 1, 16'h0000, 0, 1, 0));
		// quoted space stays in the program name, tab ends it
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_SPACE,  1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_TAB,    1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_SPACE,  1'b0, 0, NO_PIECE);
		// odd run before a quote gives a literal quote
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		// even run before a quote opens quoting
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		// doubled quote inside quotes
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		// held quote with owed backslashes, resolved by a backslash
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_QUOTE,  1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		add_row(cla_pkg::CH_SPACE,  1'b0, 0, NO_PIECE);
		// line end between arguments
		add_row(16'hFFFF, 1'b1, 1, piece(0, 0, '0, 0, 0, 1));
		// unclosed quote in the program name at line end
		add_row(cla_pkg::CH_QUOTE, 1'b0, 0, NO_PIECE);
		add_row(16'h0000, 1'b1, 1, piece(0, 0, '0, 1, 1, 1));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].cu, directed_rows[i].le, directed_rows[i].typed,
				directed_rows[i].want);

		// long backslash runs, an odd one before a quote, one before line end
		offer_item(16'h0070, 1'b0, 0, NO_PIECE);
		offer_item(cla_pkg::CH_SPACE, 1'b0, 0, NO_PIECE);
		offer_item(16'h0061, 1'b0, 0, NO_PIECE);
		repeat (LONG_RUN) offer_item(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		offer_item(cla_pkg::CH_QUOTE, 1'b0, 0, NO_PIECE);
		repeat (LONG_RUN) offer_item(cla_pkg::CH_BSLASH, 1'b0, 0, NO_PIECE);
		offer_item(16'h0000, 1'b1, 0, NO_PIECE);

		// random command lines
		while (random_items < RANDOM_ITEMS) begin
			send_line();
			if (!hold_done && random_items >= HOLD_AT) begin
				hold_done = 1;
				hold_req = 1;
			end
			if (!drain_done && random_items >= DRAIN_AT) begin
				drain_done = 1;
				item_valid <= 1'b0;
				do
					@(posedge clk);
				while (pieces_due.size() != 0);
			end
			if (random_items >= CALM_ITEMS)
				calm = 1;
		end
		item_valid <= 1'b0;

		// drain and let the pipeline settle
		while (pieces_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("command_line_argument_splitter test passed");
		else
			$display("command_line_argument_splitter test failed");
		$finish;
	end

endmodule
